>>> rtl/ledc_pkg.sv
// Shared types and constants of the log entry deframer and checker.
package ledc_pkg;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_RECORD  = 2'd1,
        PH_TRAILER = 2'd2,
        PH_SKIP    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_NONCANON  = 3'd3,
        ST_CRC       = 3'd4,
        ST_IDOVF     = 3'd5
    } t_status;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

endpackage

>>> rtl/log_entry_deframer_checker_core.sv
// Top level of the log entry deframer and checker.
// A result is loaded into the output register on the transfer of the byte that ends an
// entry. Throughput: one byte per cycle, set by the single-step
// byte CRC and the entry counters. Input stalls only while a result waits under an output stall.
// Reset (synchronous, i_rst_n low): entry state cleared, CRC all ones, entry index
// and entries_before zero, no result pending.
module log_entry_deframer_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_prefix_len,
    output logic [31:0] o_body_len,
    output logic [32:0] o_consumed,
    output logic [31:0] o_check_value,
    output logic [63:0] o_log_id
);

    ledc_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_length_accum, n_length_accum;
    logic [2:0]  r_prefix_count, n_prefix_count;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_crc, n_crc;
    logic [1:0]  r_trailer_count, n_trailer_count;
    logic [23:0] r_stored_check, n_stored_check;
    logic [63:0] r_entry_index, n_entry_index;
    logic [63:0] r_entries_before;

    logic        r_out_valid;
    logic [2:0]  r_status, n_status;
    logic [2:0]  r_prefix_len, n_prefix_len;
    logic [31:0] r_body_len, n_body_len;
    logic [32:0] r_consumed, n_consumed;
    logic [31:0] r_check_value, n_check_value;
    logic [63:0] r_log_id, n_log_id;

    logic        accept;
    logic [31:0] crc_next;
    logic [31:0] len_part;
    logic [31:0] len_next;
    logic [64:0] id_sum;
    logic        pre_ovf, pre_last, pre_noncanon;
    logic        trl_done, crc_bad, id_ovf, entry_ok, entry_err, trunc, has_result;

    ledc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_data_byte),
        .o_crc  (crc_next)
    );

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    always_comb begin
        case (r_prefix_count)
            3'd0:    len_part = {25'b0, i_data_byte[6:0]};
            3'd1:    len_part = {18'b0, i_data_byte[6:0], 7'b0};
            3'd2:    len_part = {11'b0, i_data_byte[6:0], 14'b0};
            3'd3:    len_part = {4'b0, i_data_byte[6:0], 21'b0};
            default: len_part = {i_data_byte[3:0], 28'b0};
        endcase
    end

    assign len_next = r_length_accum | len_part;
    assign id_sum   = {1'b0, r_entries_before} + {1'b0, r_entry_index};

    // event decode for the byte under transfer
    always_comb begin
        pre_ovf      = (r_phase == ledc_pkg::PH_PREFIX) && (r_prefix_count >= 3'd4)
                       && (i_data_byte > 8'h0F);
        pre_last     = (r_phase == ledc_pkg::PH_PREFIX) && !pre_ovf && !i_data_byte[7];
        pre_noncanon = pre_last && (r_prefix_count != 3'd0) && (i_data_byte == 8'h00);
        trl_done     = (r_phase == ledc_pkg::PH_TRAILER) && (r_trailer_count == 2'd3);
        crc_bad      = trl_done && ({i_data_byte, r_stored_check} != ~r_crc);
        id_ovf       = trl_done && !crc_bad && id_sum[64];
        entry_ok     = trl_done && !crc_bad && !id_ovf;
        entry_err    = pre_ovf || pre_noncanon || crc_bad || id_ovf;
        trunc        = i_end_of_buffer && !entry_ok && !entry_err
                       && (r_phase != ledc_pkg::PH_SKIP);
        has_result   = entry_ok || entry_err || trunc;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_end_of_buffer) begin
            n_phase = ledc_pkg::PH_PREFIX;
        end else begin
            case (r_phase)
                ledc_pkg::PH_PREFIX: begin
                    if (pre_ovf || pre_noncanon) begin
                        n_phase = ledc_pkg::PH_SKIP;
                    end else if (pre_last) begin
                        n_phase = (len_next != 32'd0) ? ledc_pkg::PH_RECORD
                                                      : ledc_pkg::PH_TRAILER;
                    end
                end
                ledc_pkg::PH_RECORD: begin
                    if (r_bytes_left == 32'd1) begin
                        n_phase = ledc_pkg::PH_TRAILER;
                    end
                end
                ledc_pkg::PH_TRAILER: begin
                    if (trl_done) begin
                        n_phase = entry_ok ? ledc_pkg::PH_PREFIX : ledc_pkg::PH_SKIP;
                    end
                end
                default: n_phase = ledc_pkg::PH_SKIP;
            endcase
        end
    end

    // entry datapath and result fields
    always_comb begin
        n_length_accum  = r_length_accum;
        n_prefix_count  = r_prefix_count;
        n_bytes_left    = r_bytes_left;
        n_crc           = r_crc;
        n_trailer_count = r_trailer_count;
        n_stored_check  = r_stored_check;
        n_entry_index   = r_entry_index;

        case (r_phase)
            ledc_pkg::PH_PREFIX: begin
                n_crc = crc_next;
                if (!pre_ovf) begin
                    n_length_accum = len_next;
                    n_prefix_count = r_prefix_count + 3'd1;
                end
                if (pre_last) begin
                    n_bytes_left    = len_next;
                    n_trailer_count = 2'd0;
                    n_stored_check  = 24'd0;
                end
            end
            ledc_pkg::PH_RECORD: begin
                n_crc        = crc_next;
                n_bytes_left = r_bytes_left - 32'd1;
            end
            ledc_pkg::PH_TRAILER: begin
                n_trailer_count = r_trailer_count + 2'd1;
                case (r_trailer_count)
                    2'd0:    n_stored_check[7:0]   = i_data_byte;
                    2'd1:    n_stored_check[15:8]  = i_data_byte;
                    2'd2:    n_stored_check[23:16] = i_data_byte;
                    default: n_stored_check        = r_stored_check;
                endcase
            end
            default: n_crc = r_crc;
        endcase

        if (entry_ok) begin
            n_entry_index = r_entry_index + 64'd1;
        end
        if (entry_ok || i_end_of_buffer) begin
            n_length_accum  = 32'd0;
            n_prefix_count  = 3'd0;
            n_bytes_left    = 32'd0;
            n_crc           = ledc_pkg::CRC_INIT;
            n_trailer_count = 2'd0;
            n_stored_check  = 24'd0;
        end
        if (i_end_of_buffer) begin
            n_entry_index = 64'd0;
        end

        n_status      = ledc_pkg::ST_OK;
        n_prefix_len  = 3'd0;
        n_body_len    = 32'd0;
        n_consumed    = 33'd0;
        n_check_value = 32'd0;
        n_log_id      = 64'd0;
        if (entry_ok) begin
            n_prefix_len  = r_prefix_count;
            n_body_len    = r_length_accum;
            n_consumed    = {30'b0, r_prefix_count} + {1'b0, r_length_accum} + 33'd4;
            n_check_value = ~r_crc;
            n_log_id      = id_sum[63:0];
        end else if (pre_ovf) begin
            n_status = ledc_pkg::ST_OVERFLOW;
        end else if (pre_noncanon) begin
            n_status = ledc_pkg::ST_NONCANON;
        end else if (crc_bad) begin
            n_status = ledc_pkg::ST_CRC;
        end else if (id_ovf) begin
            n_status = ledc_pkg::ST_IDOVF;
        end else begin
            n_status = ledc_pkg::ST_TRUNCATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= ledc_pkg::PH_PREFIX;
            r_length_accum   <= 32'd0;
            r_prefix_count   <= 3'd0;
            r_bytes_left     <= 32'd0;
            r_crc            <= ledc_pkg::CRC_INIT;
            r_trailer_count  <= 2'd0;
            r_stored_check   <= 24'd0;
            r_entry_index    <= 64'd0;
            r_entries_before <= 64'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entries_before <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase         <= n_phase;
                r_length_accum  <= n_length_accum;
                r_prefix_count  <= n_prefix_count;
                r_bytes_left    <= n_bytes_left;
                r_crc           <= n_crc;
                r_trailer_count <= n_trailer_count;
                r_stored_check  <= n_stored_check;
                r_entry_index   <= n_entry_index;
            end
            if (accept && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded on a transfer that yields a result
    always_ff @(posedge i_clk) begin
        if (accept && has_result) begin
            r_status      <= n_status;
            r_prefix_len  <= n_prefix_len;
            r_body_len    <= n_body_len;
            r_consumed    <= n_consumed;
            r_check_value <= n_check_value;
            r_log_id      <= n_log_id;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_prefix_len  = r_prefix_len;
    assign o_body_len    = r_body_len;
    assign o_consumed    = r_consumed;
    assign o_check_value = r_check_value;
    assign o_log_id      = r_log_id;

endmodule

>>> rtl/ledc_crc_byte.sv
// One byte step of the reflected CRC-32C.
module ledc_crc_byte (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    logic [31:0] v_crc;

    always_comb begin
        v_crc = i_crc ^ {24'b0, i_byte};
        for (int k = 0; k < 8; k++) begin
            v_crc = v_crc[0] ? ((v_crc >> 1) ^ ledc_pkg::CRC_POLY) : (v_crc >> 1);
        end
        o_crc = v_crc;
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the log entry deframer and checker core.

typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  offset;
    logic [31:0] size;
    logic [32:0] consumed;
    logic [31:0] check;
    logic [63:0] id;
} t_entry_result;

typedef struct packed {
    logic [7:0] data;
    logic       eob;
} t_stream_byte;

typedef enum int {
    K_GOOD,
    K_BADCRC,
    K_NONCANON,
    K_OVERFLOW,
    K_NOISE
} t_entry_kind;

class entry_scoreboard;
    logic [63:0]      base = '0;
    ledc_pkg::t_phase ph = ledc_pkg::PH_PREFIX;
    logic [31:0]      len_acc = '0;
    logic [2:0]       pfx_cnt = '0;
    logic [31:0]      left = '0;
    logic [31:0]      crc = 32'hFFFF_FFFF;
    int               trl_cnt = 0;
    logic [31:0]      stored = '0;
    logic [63:0]      idx = '0;
    t_entry_result    awaited_entries[$];
    int               n_errors = 0;
    int               n_results = 0;
    int               n_status[6] = '{0, 0, 0, 0, 0, 0};

    static function logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
        int k;
        c = c ^ {24'd0, b};
        for (k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'h82F6_3B78) : (c >> 1);
        return c;
    endfunction

    function void clear_entry();
        len_acc = '0;
        pfx_cnt = '0;
        left    = '0;
        crc     = 32'hFFFF_FFFF;
        trl_cnt = 0;
        stored  = '0;
    endfunction

    function void deframe_byte(logic [7:0] b, logic eob);
        t_entry_result r;
        logic [31:0]   computed;
        bit            have;
        r = '0;
        have = 0;
        case (ph)
            ledc_pkg::PH_PREFIX: begin
                crc = crc32c_step(crc, b);
                if (pfx_cnt >= 3'd4 && b > 8'h0F) begin
                    r.status = ledc_pkg::ST_OVERFLOW;
                    have = 1;
                    ph = ledc_pkg::PH_SKIP;
                end else begin
                    len_acc = len_acc | ({25'd0, b[6:0]} << (7 * pfx_cnt));
                    pfx_cnt++;
                    if (!b[7]) begin
                        if (pfx_cnt > 3'd1 && b == 8'h00) begin
                            r.status = ledc_pkg::ST_NONCANON;
                            have = 1;
                            ph = ledc_pkg::PH_SKIP;
                        end else begin
                            left = len_acc;
                            trl_cnt = 0;
                            stored = '0;
                            ph = (left != 0) ? ledc_pkg::PH_RECORD : ledc_pkg::PH_TRAILER;
                        end
                    end
                end
            end
            ledc_pkg::PH_RECORD: begin
                crc = crc32c_step(crc, b);
                left--;
                if (left == 0)
                    ph = ledc_pkg::PH_TRAILER;
            end
            ledc_pkg::PH_TRAILER: begin
                stored = stored | ({24'd0, b} << (8 * trl_cnt));
                trl_cnt++;
                if (trl_cnt >= 4) begin
                    computed = ~crc;
                    have = 1;
                    if (stored != computed) begin
                        r.status = ledc_pkg::ST_CRC;
                        ph = ledc_pkg::PH_SKIP;
                    end else if (idx > (64'hFFFF_FFFF_FFFF_FFFF - base)) begin
                        r.status = ledc_pkg::ST_IDOVF;
                        ph = ledc_pkg::PH_SKIP;
                    end else begin
                        r.status   = ledc_pkg::ST_OK;
                        r.offset   = pfx_cnt;
                        r.size     = len_acc;
                        r.consumed = {30'd0, pfx_cnt} + {1'b0, len_acc} + 33'd4;
                        r.check    = computed;
                        r.id       = base + idx;
                        idx++;
                        ph = ledc_pkg::PH_PREFIX;
                        clear_entry();
                    end
                end
            end
            default: ph = ledc_pkg::PH_SKIP;
        endcase
        if (eob) begin
            if (!have && ph != ledc_pkg::PH_SKIP) begin
                r = '0;
                r.status = ledc_pkg::ST_TRUNCATED;
                have = 1;
            end
            ph = ledc_pkg::PH_PREFIX;
            clear_entry();
            idx = '0;
        end
        if (have)
            awaited_entries.push_back(r);
    endfunction

    function void check_result(t_entry_result got);
        t_entry_result want;
        logic [63:0]   e_f[6];
        logic [63:0]   g_f[6];
        string         names[6];
        int            k;
        names = '{"status", "prefix_len", "body_len", "consumed", "check_value",
                  "log_id"};
        n_results++;
        if (awaited_entries.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual status %0d",
                     $time, got.status);
            n_errors++;
            return;
        end
        want = awaited_entries.pop_front();
        if (want.status < 6)
            n_status[want.status]++;
        e_f = '{64'(want.status), 64'(want.offset), 64'(want.size), 64'(want.consumed),
                64'(want.check), want.id};
        g_f = '{64'(got.status), 64'(got.offset), 64'(got.size), 64'(got.consumed),
                64'(got.check), got.id};
        for (k = 0; k < 6; k++) begin
            if (e_f[k] !== g_f[k]) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, names[k], e_f[k], g_f[k]);
                n_errors++;
            end
        end
    endfunction

    function void check_drained();
        if (awaited_entries.size() != 0) begin
            $display("%0t: %0d results never arrived, expected status %0d, actual none",
                     $time, awaited_entries.size(), awaited_entries[0].status);
            n_errors += awaited_entries.size();
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        in_eob = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_offset;
    logic [31:0] o_size;
    logic [32:0] o_consumed;
    logic [31:0] o_check;
    logic [63:0] o_id;

    entry_scoreboard sb = new;
    t_stream_byte    stream_q[$];
    int              n_pushed = 0;
    int              n_accepted = 0;
    int              n_buffers = 0;
    int              n_cfg = 0;
    int              hold_requests = 0;
    logic            gaps_on = 1'b1;

    log_entry_deframer_checker_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_byte),
        .i_end_of_buffer (in_eob),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (o_status),
        .o_prefix_len    (o_offset),
        .o_body_len      (o_size),
        .o_consumed      (o_consumed),
        .o_check_value   (o_check),
        .o_log_id        (o_id)
    );

    always #5 clk = ~clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk) begin : sender
        logic took;
        took = in_valid && !in_stall;
        if (took) begin
            sb.deframe_byte(in_byte, in_eob);
            n_accepted++;
        end
        if (rst_n && (!in_valid || took)) begin
            if (stream_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 17)) begin
                in_valid <= 1'b1;
                in_byte  <= stream_q[0].data;
                in_eob   <= stream_q[0].eob;
                void'(stream_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : receiver
        t_entry_result got;
        int            hold_left;
        int            hold_served;
        if (out_valid && !out_stall) begin
            got.status   = o_status;
            got.offset   = o_offset;
            got.size     = o_size;
            got.consumed = o_consumed;
            got.check    = o_check;
            got.id       = o_id;
            sb.check_result(got);
        end
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 300;
            out_stall <= 1'b1;
        end else begin
            out_stall <= gaps_on && ($urandom_range(0, 99) < 17);
        end
    end

    function automatic void push_buffer(ref logic [7:0] q[$], input int cut);
        t_stream_byte sbyte;
        int           k;
        repeat (cut) void'(q.pop_back());
        for (k = 0; k < q.size(); k++) begin
            sbyte.data = q[k];
            sbyte.eob  = (k == q.size() - 1);
            stream_q.push_back(sbyte);
        end
        n_pushed += q.size();
        n_buffers++;
        q.delete();
    endfunction

    function automatic void build_entry(int len, t_entry_kind kind, ref logic [7:0] q[$]);
        logic [7:0]  pfx[$];
        logic [7:0]  rec;
        logic [31:0] v;
        logic [31:0] c;
        int          pad;
        v = len;
        do begin
            pfx.push_back({(v >> 7) != 0, v[6:0]});
            v = v >> 7;
        end while (v != 0);
        case (kind)
            K_NOISE: begin
                repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            end
            K_OVERFLOW: begin
                repeat (4) q.push_back(8'h80 | 8'($urandom_range(0, 127)));
                q.push_back(8'($urandom_range(16, 255)));
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
            end
            K_NONCANON: begin
                pfx[pfx.size() - 1] = pfx[pfx.size() - 1] | 8'h80;
                pad = $urandom_range(0, 4 - pfx.size());
                repeat (pad) pfx.push_back(8'h80);
                pfx.push_back(8'h00);
                foreach (pfx[k]) q.push_back(pfx[k]);
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                c = 32'hFFFF_FFFF;
                foreach (pfx[k]) begin
                    c = sb.crc32c_step(c, pfx[k]);
                    q.push_back(pfx[k]);
                end
                repeat (len) begin
                    rec = 8'($urandom_range(0, 255));
                    c = sb.crc32c_step(c, rec);
                    q.push_back(rec);
                end
                c = ~c;
                if (kind == K_BADCRC)
                    c = c ^ (32'd1 << $urandom_range(0, 31));
                q.push_back(c[7:0]);
                q.push_back(c[15:8]);
                q.push_back(c[23:16]);
                q.push_back(c[31:24]);
            end
        endcase
    endfunction

    task automatic gen_random_buffer();
        logic [7:0]  q[$];
        t_entry_kind kind;
        int          r;
        int          len;
        int          cut;
        repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(0, 99);
            if (r < 72)      kind = K_GOOD;
            else if (r < 80) kind = K_BADCRC;
            else if (r < 87) kind = K_NONCANON;
            else if (r < 93) kind = K_OVERFLOW;
            else             kind = K_NOISE;
            r = $urandom_range(0, 99);
            if (r < 85)      len = $urandom_range(0, 24);
            else if (r < 97) len = $urandom_range(25, 127);
            else             len = $urandom_range(128, 300);
            build_entry(len, kind, q);
        end
        cut = 0;
        if (q.size() > 1 && $urandom_range(0, 99) < 20)
            cut = $urandom_range(1, q.size() - 1);
        push_buffer(q, cut);
    endtask

    task automatic write_base(logic [63:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.base = v;
        n_cfg++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((n_accepted != n_pushed || sb.awaited_entries.size() != 0) && guard < 50000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0]  q[$];
        logic [63:0] base_v;
        int          phase_i;
        int          target;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero-length, short entries, bad CRC in the trailer
        build_entry(0, K_GOOD, q);
        push_buffer(q, 0);
        build_entry(1, K_GOOD, q);
        build_entry(5, K_GOOD, q);
        push_buffer(q, 0);
        build_entry(4, K_BADCRC, q);
        push_buffer(q, 0);
        // non-canonical prefixes, overflow, long canonical prefixes truncated
        q = '{8'h80, 8'h00, 8'h12, 8'hFF};
        push_buffer(q, 0);
        q = '{8'h80, 8'h00};
        push_buffer(q, 0);
        q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'hAA};
        push_buffer(q, 0);
        q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h8F};
        push_buffer(q, 0);
        q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hFF};
        push_buffer(q, 0);
        q = '{8'h80, 8'h80, 8'h80, 8'h01, 8'h55};
        push_buffer(q, 0);
        q = '{8'h00};
        push_buffer(q, 0);
        build_entry(2, K_GOOD, q);
        push_buffer(q, 2);
        drain();

        // id overflow at the top of the id range, index restart per buffer
        write_base(64'hFFFF_FFFF_FFFF_FFFF);
        build_entry(1, K_GOOD, q);
        build_entry(0, K_GOOD, q);
        build_entry(2, K_GOOD, q);
        push_buffer(q, 0);
        build_entry(0, K_GOOD, q);
        push_buffer(q, 0);
        drain();
        write_base(64'hFFFF_FFFF_FFFF_FFFE);
        repeat (3) build_entry($urandom_range(0, 3), K_GOOD, q);
        push_buffer(q, 0);
        drain();

        for (phase_i = 0; phase_i < 6; phase_i++) begin
            case (phase_i)
                0: base_v = {32'($urandom), 32'($urandom)};
                1: base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                2: base_v = '0;
                3: base_v = 64'($urandom_range(0, 1000));
                4: base_v = 64'h8000_0000_0000_0000;
                default: base_v = {32'($urandom), 32'($urandom)};
            endcase
            write_base(base_v);
            gaps_on <= (phase_i != 3);
            target = n_pushed + 160;
            while (n_pushed < target)
                gen_random_buffer();
            if (phase_i == 1)
                hold_requests++;
            drain();
        end

        sb.check_drained();
        $display("Run: %0d bytes in %0d buffers, %0d base settings, %0d results checked",
                 n_accepted, n_buffers, n_cfg, sb.n_results);
        $display("Status mix ok/trunc/ovf/noncanon/crc/idovf: %0d/%0d/%0d/%0d/%0d/%0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
                 sb.n_status[4], sb.n_status[5]);
        if (sb.n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/ledc_pkg.sv
rtl/ledc_crc_byte.sv
rtl/log_entry_deframer_checker_core.sv
dv/tb_top.sv
